/* hw/rtl/fbc_pkg.sv */
// ============================================================================
// fbc_pkg
// Shared types and widths for the frustum box classifier.
// ============================================================================
package fbc_pkg;

    // Six frustum planes, indexed as the configuration registers
    localparam int PLANE_COUNT = 6;
    localparam int AXIS_COUNT  = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam int COORD_W = 16;  // centre Q11.4, size Q12.4, normal Q1.14
    localparam int PROD_W  = 32;  // normal * centre, signed, 2^-18 units
    localparam int RADP_W  = 31;  // size * |normal|, unsigned, 2^-19 units
    localparam int DOT_W   = 34;  // sum of three centre products
    localparam int DIST_W  = 35;  // 2 * dot + offset * 2^15, 2^-19 units
    localparam int RAD_W   = 33;  // sum of three radius products
    localparam int CMP_W   = 36;  // dist +/- rad

    localparam int IN_DATA_W  = 96;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLANE_LEFT   = 3'd0,
        REG_PLANE_RIGHT  = 3'd1,
        REG_PLANE_BOTTOM = 3'd2,
        REG_PLANE_TOP    = 3'd3,
        REG_PLANE_NEAR   = 3'd4,
        REG_PLANE_FAR    = 3'd5
    } fbc_reg_idx_t;

    typedef enum logic [1:0] {
        CLS_INSIDE    = 2'd0,
        CLS_INTERSECT = 2'd1,
        CLS_OUTSIDE   = 2'd2
    } fbc_cls_t;

    // One plane register: normal x in the lowest bits, offset in the top
    typedef struct packed {
        logic signed [COORD_W-1:0] offset;
        logic signed [COORD_W-1:0] nz;
        logic signed [COORD_W-1:0] ny;
        logic signed [COORD_W-1:0] nx;
    } fbc_plane_t;

endpackage

/* hw/rtl/frustum_box_classifier_core.sv */
// ============================================================================
// frustum_box_classifier_core
// Six-plane axis-aligned box culling, one box per clock unless stalled, four stages.
// ============================================================================
//
// Classifies each incoming box against six frustum planes written through the
// configuration port. Every clock that input is ready the block takes one box
// word, and for each box it presents one classification word: inside,
// intersecting or outside. Throughput is one box per cycle while no stage is
// held. The stage chain is multiply -> sum -> compare -> reduce, and 36
// parallel 16x16 multipliers sit in the first stage.
// Each stage has its own valid bit and holds under backpressure only while the
// stage after it is full, so bubbles close up and input keeps flowing while a
// finished word waits at the output. The arithmetic is exact: distance and
// projected radius are both carried in units of 2^-19, ties go to the inner
// class, and a normal component of -2.0 counts with magnitude 2.0. A box word
// with box_valid low is classified outside. Plane registers reset to zero
// (every valid box then reads inside); write them only while the pipeline is empty.
// Writes to indexes six and seven are taken and dropped.
//
module frustum_box_classifier_core
(
    input  logic                                clk,
    input  logic                                rst_n,

    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fbc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fbc_pkg::CFG_DATA_W-1:0]      cfg_data,

    // Box input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] center_x, [31:16] center_y, [47:32] center_z,
    // [63:48] size_x, [79:64] size_y, [95:80] size_z
    input  logic [fbc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // [0] box_valid
    input  logic [fbc_pkg::IN_USER_W-1:0]       s_axis_tuser,

    // Classification output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] classification, [7:2] zero
    output logic [fbc_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    localparam int NP = fbc_pkg::PLANE_COUNT;
    localparam int NA = fbc_pkg::AXIS_COUNT;
    localparam int CW = fbc_pkg::COORD_W;

    // ------------------------------------------------------------------------
    // Plane registers
    // ------------------------------------------------------------------------
    fbc_pkg::fbc_plane_t plane_reg [NP];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NP; p++)
            begin
                plane_reg[p] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (fbc_pkg::fbc_reg_idx_t'(cfg_index))
                fbc_pkg::REG_PLANE_LEFT:   plane_reg[0] <= fbc_pkg::fbc_plane_t'(cfg_data);
                fbc_pkg::REG_PLANE_RIGHT:  plane_reg[1] <= fbc_pkg::fbc_plane_t'(cfg_data);
                fbc_pkg::REG_PLANE_BOTTOM: plane_reg[2] <= fbc_pkg::fbc_plane_t'(cfg_data);
                fbc_pkg::REG_PLANE_TOP:    plane_reg[3] <= fbc_pkg::fbc_plane_t'(cfg_data);
                fbc_pkg::REG_PLANE_NEAR:   plane_reg[4] <= fbc_pkg::fbc_plane_t'(cfg_data);
                fbc_pkg::REG_PLANE_FAR:    plane_reg[5] <= fbc_pkg::fbc_plane_t'(cfg_data);
                default:
                begin
                    // drop writes beyond the plane set
                end
            endcase
        end
    end

    // Normals as a per-axis array for the product loops
    logic signed [CW-1:0] nrm     [NP][NA];
    logic        [CW-1:0] nrm_mag [NP][NA];

    always_comb
    begin
        logic [CW:0] ext;
        logic [CW:0] mag;
        for (int p = 0; p < NP; p++)
        begin
            nrm[p][0] = plane_reg[p].nx;
            nrm[p][1] = plane_reg[p].ny;
            nrm[p][2] = plane_reg[p].nz;
            for (int k = 0; k < NA; k++)
            begin
                // one bit wider so that -2.0 maps to +2.0
                ext = {nrm[p][k][CW-1], nrm[p][k]};
                mag = nrm[p][k][CW-1] ? (~ext + 1'b1) : ext;
                nrm_mag[p][k] = mag[CW-1:0];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or its word moves on
    // ------------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;

    assign s4_rdy = !s4_valid_reg || m_axis_tready;
    assign s3_rdy = !s3_valid_reg || s4_rdy;
    assign s2_rdy = !s2_valid_reg || s3_rdy;
    assign s1_rdy = !s1_valid_reg || s2_rdy;

    assign s_axis_tready = s1_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_rdy) s1_valid_reg <= s_axis_tvalid;
            if (s2_rdy) s2_valid_reg <= s1_valid_reg;
            if (s3_rdy) s3_valid_reg <= s2_valid_reg;
            if (s4_rdy) s4_valid_reg <= s3_valid_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: all 36 products
    // ------------------------------------------------------------------------
    logic signed [CW-1:0] in_center [NA];
    logic        [CW-1:0] in_size   [NA];

    always_comb
    begin
        for (int k = 0; k < NA; k++)
        begin
            in_center[k] = s_axis_tdata[k*CW +: CW];
            in_size[k]   = s_axis_tdata[(NA+k)*CW +: CW];
        end
    end

    logic signed [fbc_pkg::PROD_W-1:0] s1_dprod_next [NP][NA];
    logic        [fbc_pkg::RADP_W-1:0] s1_rprod_next [NP][NA];
    logic signed [fbc_pkg::PROD_W-1:0] s1_dprod_reg  [NP][NA];
    logic        [fbc_pkg::RADP_W-1:0] s1_rprod_reg  [NP][NA];
    logic                              s1_box_reg;

    always_comb
    begin
        logic [2*CW-1:0] rp;
        for (int p = 0; p < NP; p++)
        begin
            for (int k = 0; k < NA; k++)
            begin
                s1_dprod_next[p][k] = nrm[p][k] * in_center[k];
                rp                  = in_size[k] * nrm_mag[p][k];
                // size * |n| stays below 2^31
                s1_rprod_next[p][k] = rp[fbc_pkg::RADP_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_rdy && s_axis_tvalid)
        begin
            s1_dprod_reg <= s1_dprod_next;
            s1_rprod_reg <= s1_rprod_next;
            s1_box_reg   <= s_axis_tuser[0];
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: signed distance and projected radius per plane
    // ------------------------------------------------------------------------
    localparam int DOT_X  = fbc_pkg::DOT_W - fbc_pkg::PROD_W;
    localparam int RAD_X  = fbc_pkg::RAD_W - fbc_pkg::RADP_W;
    localparam int OFF_SH = 15;

    logic signed [fbc_pkg::DIST_W-1:0] s2_dist_next [NP];
    logic        [fbc_pkg::RAD_W-1:0]  s2_rad_next  [NP];
    logic signed [fbc_pkg::DIST_W-1:0] s2_dist_reg  [NP];
    logic        [fbc_pkg::RAD_W-1:0]  s2_rad_reg   [NP];
    logic                              s2_box_reg;

    always_comb
    begin
        logic signed [fbc_pkg::DOT_W-1:0]  dot;
        logic        [fbc_pkg::RAD_W-1:0]  rad;
        logic signed [fbc_pkg::DIST_W-1:0] offs;
        for (int p = 0; p < NP; p++)
        begin
            dot = '0;
            rad = '0;
            for (int k = 0; k < NA; k++)
            begin
                dot = dot + {{DOT_X{s1_dprod_reg[p][k][fbc_pkg::PROD_W-1]}},
                             s1_dprod_reg[p][k]};
                rad = rad + {{RAD_X{1'b0}}, s1_rprod_reg[p][k]};
            end
            offs = {{(fbc_pkg::DIST_W-CW-OFF_SH){plane_reg[p].offset[CW-1]}},
                    plane_reg[p].offset, {OFF_SH{1'b0}}};
            s2_dist_next[p] = {dot, 1'b0} + offs;
            s2_rad_next[p]  = rad;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_rdy && s1_valid_reg)
        begin
            s2_dist_reg <= s2_dist_next;
            s2_rad_reg  <= s2_rad_next;
            s2_box_reg  <= s1_box_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: per-plane outside (d < -r) and intersect (d < r) flags
    // ------------------------------------------------------------------------
    logic [NP-1:0] s3_out_next, s3_int_next;
    logic [NP-1:0] s3_out_reg, s3_int_reg;
    logic          s3_box_reg;

    always_comb
    begin
        logic signed [fbc_pkg::CMP_W-1:0] d;
        logic signed [fbc_pkg::CMP_W-1:0] r;
        logic signed [fbc_pkg::CMP_W-1:0] sum;
        logic signed [fbc_pkg::CMP_W-1:0] diff;
        for (int p = 0; p < NP; p++)
        begin
            d    = {s2_dist_reg[p][fbc_pkg::DIST_W-1], s2_dist_reg[p]};
            r    = {{(fbc_pkg::CMP_W-fbc_pkg::RAD_W){1'b0}}, s2_rad_reg[p]};
            sum  = d + r;
            diff = d - r;
            s3_out_next[p] = sum[fbc_pkg::CMP_W-1];
            s3_int_next[p] = diff[fbc_pkg::CMP_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_rdy && s2_valid_reg)
        begin
            s3_out_reg <= s3_out_next;
            s3_int_reg <= s3_int_next;
            s3_box_reg <= s2_box_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: reduce flags to the class, hold it as the output word
    // ------------------------------------------------------------------------
    fbc_pkg::fbc_cls_t s4_cls_next, s4_cls_reg;

    always_comb
    begin
        if (!s3_box_reg || (|s3_out_reg))
        begin
            s4_cls_next = fbc_pkg::CLS_OUTSIDE;
        end
        else if (|s3_int_reg)
        begin
            s4_cls_next = fbc_pkg::CLS_INTERSECT;
        end
        else
        begin
            s4_cls_next = fbc_pkg::CLS_INSIDE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_rdy && s3_valid_reg)
        begin
            s4_cls_reg <= s4_cls_next;
        end
    end

    assign m_axis_tvalid = s4_valid_reg;
    assign m_axis_tdata  = {{(fbc_pkg::OUT_DATA_W-2){1'b0}}, s4_cls_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // An outside flag can never stand without the intersect flag (r >= 0)
    a_out_implies_int: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> ((s3_out_reg & ~s3_int_reg) == '0))
        else $error("outside flag set without intersect flag");

    // An invalid box word leaves stage 3 as outside
    a_invalid_box_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && s4_rdy && !s3_box_reg) |=>
            (s4_cls_reg == fbc_pkg::CLS_OUTSIDE))
        else $error("invalid box not classified outside");

    // Any plane rejecting a valid box makes it outside
    a_plane_reject_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && s4_rdy && s3_box_reg && (|s3_out_reg)) |=>
            (s4_cls_reg == fbc_pkg::CLS_OUTSIDE))
        else $error("rejected box not classified outside");

    // A blocked middle stage keeps its word
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s3_rdy) |=>
            (s2_valid_reg && $stable(s2_box_reg) && $stable(s2_dist_reg[0])))
        else $error("stage 2 word lost under stall");

    // The output word never carries the unused class code
    a_cls_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'b11))
        else $error("illegal class code on output");

endmodule

/* bench/tb_frustum_box_classifier_core.sv */
// ============================================================================
// tb_frustum_box_classifier_core
// Self-checking bench for the six-plane box classifier.
// ============================================================================
//
// Streams box words into the core and checks every classification word
// against a local exact-integer classifier. The classifier runs on a shadow
// copy of the six plane registers. The bench starts with directed cases:
// reset planes, exact ties on both sides, a normal component of -2.0, field
// and register extremes, and writes to the unused indexes. It then streams
// well-formed random frustums with random boxes, then noise words.
// Both stream sides idle in random bursts. The last stretch runs at full rate.
//
module tb_frustum_box_classifier_core;

    timeunit 1ns;
    timeprecision 1ps;

    // Indexes past the last plane; the core takes these writes and drops them
    localparam logic [fbc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [fbc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TICKS = 16;     // longer than the four-stage pipeline takes to drain

    typedef logic [fbc_pkg::CFG_DATA_W-1:0] plane_set_t [fbc_pkg::PLANE_COUNT];

    // One box word as the core sees it
    typedef struct packed {
        logic                               valid;
        logic signed [fbc_pkg::COORD_W-1:0] cx;
        logic signed [fbc_pkg::COORD_W-1:0] cy;
        logic signed [fbc_pkg::COORD_W-1:0] cz;
        logic [fbc_pkg::COORD_W-1:0]        sx;
        logic [fbc_pkg::COORD_W-1:0]        sy;
        logic [fbc_pkg::COORD_W-1:0]        sz;
    } box_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [fbc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [fbc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [fbc_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [fbc_pkg::IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [fbc_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    // Shadow of the plane registers, as the classifier sees them
    logic [fbc_pkg::CFG_DATA_W-1:0] plane_shadow [fbc_pkg::PLANE_COUNT];
    // Classes still owed by the core, oldest first
    fbc_pkg::fbc_cls_t              predicted_classes [$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    bit  gap_enable = 1'b1;    // sender may idle
    bit  stall_enable = 1'b1;  // receiver may stall

    frustum_box_classifier_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Exact classifier. Distance and radius both live in 2^-19 units:
    // distance = 2 * (n . c) + offset * 2^15, rad = size . |n|.
    // ------------------------------------------------------------------------
    function automatic fbc_pkg::fbc_cls_t classify_box(box_t b);
        longint              c [3];
        longint              s [3];
        longint              n [3];
        longint              dot;
        longint              rad;
        longint              distance;
        longint              off;
        fbc_pkg::fbc_plane_t pl;
        logic                hit;
        if (!b.valid)
            return fbc_pkg::CLS_OUTSIDE;
        c[0] = b.cx;
        c[1] = b.cy;
        c[2] = b.cz;
        s[0] = b.sx;
        s[1] = b.sy;
        s[2] = b.sz;
        hit = 1'b0;
        for (int p = 0; p < fbc_pkg::PLANE_COUNT; p++)
        begin
            pl   = plane_shadow[p];
            n[0] = pl.nx;
            n[1] = pl.ny;
            n[2] = pl.nz;
            off  = pl.offset;
            dot  = 0;
            rad  = 0;
            for (int k = 0; k < 3; k++)
            begin
                dot += n[k] * c[k];
                // -2.0 counts with magnitude 2.0, no wrap at 64 bits
                rad += s[k] * ((n[k] < 0) ? -n[k] : n[k]);
            end
            distance = 2 * dot + off * 32768;
            // Strict compares: ties fall to the inner class
            if (distance < -rad)
                return fbc_pkg::CLS_OUTSIDE;
            if (distance < rad)
                hit = 1'b1;
        end
        return hit ? fbc_pkg::CLS_INTERSECT : fbc_pkg::CLS_INSIDE;
    endfunction

    function automatic logic [fbc_pkg::CFG_DATA_W-1:0] pack_plane(
        logic [15:0] nx, logic [15:0] ny, logic [15:0] nz, logic [15:0] off);
        return {off, nz, ny, nx};
    endfunction

    function automatic box_t make_box(logic v, logic [15:0] cx, logic [15:0] cy,
                                      logic [15:0] cz, logic [15:0] sx,
                                      logic [15:0] sy, logic [15:0] sz);
        box_t b;
        b.valid = v;
        b.cx = cx;
        b.cy = cy;
        b.cz = cz;
        b.sx = sx;
        b.sy = sy;
        b.sz = sz;
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // Configuration writes; the caller guarantees the pipeline is empty
    // ------------------------------------------------------------------------
    task automatic write_plane_reg(logic [fbc_pkg::CFG_IDX_W-1:0] idx,
                                   logic [fbc_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx < fbc_pkg::PLANE_COUNT)
            plane_shadow[idx] = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_planes(plane_set_t planes);
        for (int p = 0; p < fbc_pkg::PLANE_COUNT; p++)
            write_plane_reg(fbc_pkg::fbc_reg_idx_t'(p), planes[p]);
    endtask

    // Drop valid and hold until every owed class has come back
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (predicted_classes.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Send one box word; a random idle burst may come first
    // ------------------------------------------------------------------------
    task automatic send_box(box_t b);
        @(negedge clk);
        if (gap_enable && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b.sz, b.sy, b.sx, b.cz, b.cy, b.cx};
        s_axis_tuser  <= b.valid;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted_classes.push_back(classify_box(b));
    endtask

    // Receiver: hold ready low in random bursts
    always
    begin
        @(negedge clk);
        if (stall_enable && $urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        m_axis_tready <= 1'b1;
    end

    // Compare each accepted classification word with the oldest prediction
    always @(posedge clk)
    begin : check_words
        fbc_pkg::fbc_cls_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (predicted_classes.size() == 0)
            begin
                $error("classification: no word expected, got %0d", m_axis_tdata[1:0]);
                mismatch_count++;
            end
            else
            begin
                want = predicted_classes.pop_front();
                if (m_axis_tdata[1:0] !== want)
                begin
                    $error("classification: expected %0d, got %0d", want, m_axis_tdata[1:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[fbc_pkg::OUT_DATA_W-1:2] !== '0)
                begin
                    $error("pad: expected 0, got %0h", m_axis_tdata[fbc_pkg::OUT_DATA_W-1:2]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Random frustum: each plane faces inward along its own axis with some
    // tilt; now and then a plane is pure noise
    // ------------------------------------------------------------------------
    task automatic load_random_frustum();
        plane_set_t  planes;
        logic [15:0] comp [3];
        logic [15:0] main_n;
        int          axis;
        for (int p = 0; p < fbc_pkg::PLANE_COUNT; p++)
        begin
            axis   = p / 2;
            main_n = 16'($urandom_range(16'h2000, 16'h7FFF));
            if (p % 2 == 1)
                main_n = -main_n;
            for (int k = 0; k < 3; k++)
                comp[k] = (k == axis) ? main_n : 16'($urandom_range(0, 16'h1000) - 16'h0800);
            if ($urandom_range(0, 4) == 0)
                planes[p] = {$urandom, $urandom};
            else
                planes[p] = pack_plane(comp[0], comp[1], comp[2],
                                       16'($urandom_range(0, 16'h3000)));
        end
        drain_results();
        set_planes(planes);
    endtask

    // Boxes near the frustum: mostly small, some of any size
    function automatic box_t random_scene_box();
        logic [15:0] sz [3];
        for (int k = 0; k < 3; k++)
            sz[k] = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 16'h0C00))
                                                : 16'($urandom);
        return make_box($urandom_range(0, 15) != 0,
                        16'($urandom_range(0, 16'h6000) - 16'h3000),
                        16'($urandom_range(0, 16'h6000) - 16'h3000),
                        16'($urandom_range(0, 16'h6000) - 16'h3000),
                        sz[0], sz[1], sz[2]);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // All planes zero after reset: every valid box reads inside
    task automatic test_reset_planes();
        send_box(make_box(1'b1, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));
        send_box(make_box(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_box(make_box(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    endtask

    // Cube of half-width 1000 LSB: hit both tie boundaries exactly
    task automatic test_tie_boundaries();
        drain_results();
        set_planes('{pack_plane(16'h4000, 16'h0000, 16'h0000, 16'd1000),
                     pack_plane(16'hC000, 16'h0000, 16'h0000, 16'd1000),
                     pack_plane(16'h0000, 16'h4000, 16'h0000, 16'd1000),
                     pack_plane(16'h0000, 16'hC000, 16'h0000, 16'd1000),
                     pack_plane(16'h0000, 16'h0000, 16'h4000, 16'd1000),
                     pack_plane(16'h0000, 16'h0000, 16'hC000, 16'd1000)});
        // Faces touch every plane: d == r is still inside
        send_box(make_box(1'b1, 16'd0, 16'd0, 16'd0, 16'd2000, 16'd2000, 16'd2000));
        send_box(make_box(1'b1, 16'd0, 16'd0, 16'd0, 16'd2001, 16'd2000, 16'd2000));
        // Box just touching the left plane from outside: d == -r is not outside
        send_box(make_box(1'b1, -16'sd1100, 16'd0, 16'd0, 16'd200, 16'd200, 16'd200));
        send_box(make_box(1'b1, -16'sd1101, 16'd0, 16'd0, 16'd200, 16'd200, 16'd200));
        send_box(make_box(1'b0, 16'd0, 16'd0, 16'd0, 16'd2000, 16'd2000, 16'd2000));
        // Writes past the last plane must leave the planes alone
        drain_results();
        write_plane_reg(REG_SPARE_LO, '1);
        write_plane_reg(REG_SPARE_HI, '1);
        send_box(make_box(1'b1, 16'd0, 16'd0, 16'd0, 16'd2000, 16'd2000, 16'd2000));
    endtask

    // Normal x of -2.0 on the left plane, all else zero
    task automatic test_negative_two_normal();
        drain_results();
        set_planes('{pack_plane(16'h8000, 16'h0000, 16'h0000, 16'h0000),
                     '0, '0, '0, '0, '0});
        send_box(make_box(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_box(make_box(1'b1, 16'd0, 16'd0, 16'd0, 16'd5, 16'd0, 16'd0));
        send_box(make_box(1'b1, 16'd1, 16'd0, 16'd0, 16'd2, 16'd0, 16'd0));
        send_box(make_box(1'b1, 16'd1, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0));
    endtask

    // Extreme register patterns against extreme boxes
    task automatic test_field_extremes();
        logic [fbc_pkg::CFG_DATA_W-1:0] pattern [3];
        pattern[0] = 64'h7FFF_7FFF_7FFF_7FFF;
        pattern[1] = 64'h8000_8000_8000_8000;
        pattern[2] = '1;
        for (int i = 0; i < 3; i++)
        begin
            drain_results();
            set_planes('{pattern[i], pattern[i], pattern[i],
                         pattern[i], pattern[i], pattern[i]});
            send_box(make_box(1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
            send_box(make_box(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000));
            send_box(make_box(1'b1, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 16'hFFFF));
        end
    endtask

    task automatic test_random_frustums(int scenes, int boxes);
        for (int i = 0; i < scenes; i++)
        begin
            load_random_frustum();
            repeat (boxes) send_box(random_scene_box());
        end
    endtask

    // Fully random box words: every input bit toggles
    task automatic test_random_noise(int scenes, int boxes);
        box_t b;
        for (int i = 0; i < scenes; i++)
        begin
            load_random_frustum();
            repeat (boxes)
            begin
                b = make_box(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                send_box(b);
            end
        end
    endtask

    // Full rate on both sides to close the run
    task automatic test_quiet_tail(int boxes);
        drain_results();
        gap_enable   = 1'b0;
        stall_enable = 1'b0;
        test_random_frustums(1, boxes);
    endtask

    initial
    begin
        for (int p = 0; p < fbc_pkg::PLANE_COUNT; p++)
            plane_shadow[p] = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_planes();
        test_tie_boundaries();
        test_negative_two_normal();
        test_field_extremes();
        test_random_frustums(10, 125);
        test_random_noise(5, 50);
        test_quiet_tail(60);

        drain_results();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
